// ----- sv/dwid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dwid_pkg;

   // Field widths fixed by the request and response formats.
   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 30;
   localparam int INDEX_W  = 10;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   // Operation codes carried by a request.
   localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd2;

   // Outcome codes reported on every response of a run.
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;      // capture the request fields
      logic exec;       // carry out the operation
      logic shift_rd;   // read the entry one place behind the gap
      logic shift_wr;   // move that entry forward into the gap
      logic shift_end;  // close the list after a delete
      logic fwd_issue;  // read one entry of the head-to-tail pass
      logic rev_issue;  // read one entry of the tail-to-head pass
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic delete_ok;  // delete request with an index inside the list
      logic shift_more; // another entry still has to move forward
      logic pass_end;   // the current pass is on its final entry
   } sts_type;

endpackage

`default_nettype wire

// ----- sv/dwid_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwid_ctrl
   import dwid_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     start,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SH_RD = 3'd2;
   localparam logic [2:0] S_SH_WR = 3'd3;
   localparam logic [2:0] S_FWD   = 3'd4;
   localparam logic [2:0] S_REV   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.delete_ok ? S_SH_RD : S_FWD;
         end
         S_SH_RD: begin
            if (sts.shift_more) begin
               ctl.shift_rd = 1'b1;
               state_in     = S_SH_WR;
            end else begin
               ctl.shift_end = 1'b1;
               state_in      = S_FWD;
            end
         end
         S_SH_WR: begin
            ctl.shift_wr = 1'b1;
            state_in     = S_SH_RD;
         end
         S_FWD: begin
            ctl.fwd_issue = 1'b1;
            if (sts.pass_end) begin
               state_in = S_REV;
            end
         end
         S_REV: begin
            ctl.rev_issue = 1'b1;
            if (sts.pass_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/dwid_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwid_datapath
   import dwid_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  wire                  clock,
   input  wire                  reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  wire [CMD_W-1:0]      req_cmd,
   input  wire [VALUE_W-1:0]    req_value,
   input  wire [INDEX_W-1:0]    req_index,
   output logic                 rsp_valid,
   output logic                 rsp_direction,
   output logic [VALUE_W-1:0]   rsp_element,
   output logic [POS_W-1:0]     rsp_position,
   output logic                 rsp_empty_res,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // List storage, one read and one write port.
   logic [VALUE_W-1:0] mem [DEPTH];

   logic [CMD_W-1:0]    cmd_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       iter_ff, iter_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  rdata_ff;

   logic                valid_ff;
   logic                dir_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                empty_ff;
   logic                last_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   logic                full;
   logic                count_zero;
   logic [CW:0]         iter_inc;
   logic [CW-1:0]       rev_pos;
   logic [AW-1:0]       head_dec;

   // Physical slot of a list position: head plus offset, wrapped once.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
      logic [AW:0] sum;
      begin
         sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
         if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
         end
         slot_of = sum[AW-1:0];
      end
   endfunction

   assign full       = (count_ff == DEPTH_C);
   assign count_zero = (count_ff == '0);
   assign iter_inc   = {1'b0, iter_ff} + (CW + 1)'(1);
   assign rev_pos    = count_ff - CW'(1) - iter_ff;
   assign head_dec   = (head_ff == '0) ? LAST_SLOT : (head_ff - AW'(1));

   // Status towards the controller.
   always_comb begin
      sts.delete_ok  = (cmd_ff == CMD_DELETE) &&
                       (CMP_W'(index_ff) < CMP_W'(count_ff));
      sts.shift_more = (iter_inc < {1'b0, count_ff});
      sts.pass_end   = count_zero || (iter_inc == {1'b0, count_ff});
   end

   // Operation, shift and pass bookkeeping.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      iter_in   = iter_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_of(head_ff, iter_ff);
      wr_data   = rdata_ff;
      rd_en     = 1'b0;
      rd_addr   = slot_of(head_ff, iter_inc[CW-1:0]);

      if (ctl.exec) begin
         iter_in   = '0;
         status_in = STATUS_DONE;
         case (cmd_ff)
            CMD_PUSH_HEAD: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  wr_data  = value_ff;
               end
            end
            CMD_PUSH_TAIL: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(head_ff, count_ff);
                  wr_data  = value_ff;
               end
            end
            CMD_DELETE: begin
               if (sts.delete_ok) begin
                  iter_in = CW'(index_ff);
               end else begin
                  status_in = STATUS_BAD_INDEX;
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end

      if (ctl.shift_rd) begin
         rd_en = 1'b1;
      end

      if (ctl.shift_wr) begin
         wr_en   = 1'b1;
         iter_in = iter_inc[CW-1:0];
      end

      if (ctl.shift_end) begin
         count_in = count_ff - CW'(1);
         iter_in  = '0;
      end

      if (ctl.fwd_issue || ctl.rev_issue) begin
         rd_en   = 1'b1;
         rd_addr = ctl.rev_issue ? slot_of(head_ff, rev_pos) : slot_of(head_ff, iter_ff);
         iter_in = sts.pass_end ? '0 : iter_inc[CW-1:0];
      end
   end

   // Storage write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Storage read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Captured request fields.
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         index_ff <= req_index;
      end
   end

   // List pointers, loop counter and outcome.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         iter_ff   <= '0;
         status_ff <= STATUS_DONE;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         iter_ff   <= iter_in;
         status_ff <= status_in;
      end
   end

   // Response tags travel alongside the read and appear in the cycle after the issue.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.fwd_issue || ctl.rev_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fwd_issue || ctl.rev_issue) begin
         dir_ff   <= ctl.rev_issue;
         pos_ff   <= POS_W'(iter_ff);
         empty_ff <= count_zero;
         last_ff  <= ctl.rev_issue && sts.pass_end;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_direction = dir_ff;
   assign rsp_element   = empty_ff ? '0 : rdata_ff;
   assign rsp_position  = empty_ff ? '0 : pos_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ----- sv/deque_with_indexed_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to DEPTH 30-bit values, kept in a circular store.
// A request is taken at a rising edge with start high and busy low; req_cmd
// selects insert at head, insert at tail or delete at req_index.
// After the operation the whole list is sent out on the rsp_ ports, head to
// tail and then tail to head, one response per cycle marked by rsp_valid,
// with rsp_last on the final one. An empty list gives one response per pass
// with rsp_empty_res set. An insert into a full list and a delete beyond the
// list change nothing and are reported on rsp_status.
// An insert or a rejected delete goes straight to the two passes. A delete at
// index k of n entries first moves the n-1-k entries behind it forward, each
// read and then written one place nearer the head, and then closes the gap.
// Busy stays high from acceptance until the reverse pass has issued its last
// read, including the shift of a delete; the last response is shown in the
// first cycle with busy low. No new request is taken while busy is high, and
// both passes are fed by the one read port of the store.
// Reset clears the list to empty and drops any run in progress. Responses
// cannot be held off by the receiver and each is present for one cycle only.

module deque_with_indexed_delete
   import dwid_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire [CMD_W-1:0]      req_cmd,
   input  wire [VALUE_W-1:0]    req_value,
   input  wire [INDEX_W-1:0]    req_index,
   output logic                 rsp_valid,
   output logic                 rsp_direction,
   output logic [VALUE_W-1:0]   rsp_element,
   output logic [POS_W-1:0]     rsp_position,
   output logic                 rsp_empty_res,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last
);

   ctl_type ctl;
   sts_type sts;

   // Sequencer.
   dwid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   // Store, pointers and response stage.
   dwid_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_direction (rsp_direction),
      .rsp_element   (rsp_element),
      .rsp_position  (rsp_position),
      .rsp_empty_res (rsp_empty_res),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// ----- sv/dwid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwid_checker
   import dwid_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 start,
   input wire                 busy,
   input wire                 rsp_valid,
   input wire                 rsp_direction,
   input wire [VALUE_W-1:0]   rsp_element,
   input wire [POS_W-1:0]     rsp_position,
   input wire                 rsp_empty_res,
   input wire                 rsp_last
);

   // An accepted request keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

   // Responses of one run follow each other without gaps.
   a_run_dense: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a response run");

   // The final response belongs to the tail-to-head pass.
   a_last_reverse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_direction)
      else $error("last response not in the reverse pass");

   // An empty-list response carries zero element and position.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_element == '0 && rsp_position == '0))
      else $error("empty response with non-zero payload");

   // Nothing is sent out in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("activity straight after reset");

endmodule

bind deque_with_indexed_delete dwid_checker u_dwid_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_direction (rsp_direction),
   .rsp_element   (rsp_element),
   .rsp_position  (rsp_position),
   .rsp_empty_res (rsp_empty_res),
   .rsp_last      (rsp_last)
);

`default_nettype wire
